@@ rtl/frsm_pkg.sv @@
// Shared constants and controller/datapath handshake types for the frame reassembly slot manager.
`timescale 1ns / 1ps
package frsm_pkg;

	localparam int SLOT_COUNT_DEF  = 3;
	localparam int CHUNK_BYTES_DEF = 4096;

	localparam int STAMP_W  = 32;
	localparam int CHUNK_W  = 16;
	localparam int BYTES_W  = 24;
	localparam int DIM_W    = 12;
	localparam int FMT_W    = 8;
	localparam int SLOTID_W = 2;
	localparam int OFFSET_W = 28;

	localparam logic OP_PACKET = 1'b0;
	localparam logic OP_FETCH  = 1'b1;

	typedef struct packed {
		logic load;
		logic scan;
		logic commit;
	} frsm_cmd_t;

	typedef struct packed {
		logic scan_last;
		logic out_blocked;
	} frsm_sts_t;

endpackage

@@ rtl/frsm_ctrl.sv @@
// Controller state machine: accept a beat, scan the slots, commit the result.
`timescale 1ns / 1ps
module frsm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  frsm_pkg::frsm_sts_t sts,
	output frsm_pkg::frsm_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_COMMIT
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (sts.scan_last) begin
						state_q <= ST_COMMIT;
					end
				end
				ST_COMMIT: begin
					if (!sts.out_blocked) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		cmd        = '0;
		cmd.load   = (state_q == ST_IDLE) && in_valid;
		cmd.scan   = (state_q == ST_SCAN);
		cmd.commit = (state_q == ST_COMMIT) && !sts.out_blocked;
	end

endmodule

@@ rtl/frsm_dp.sv @@
// Datapath: input register, slot state, serial slot scan and output register.
`timescale 1ns / 1ps
module frsm_dp #(
	parameter int SLOT_COUNT  = frsm_pkg::SLOT_COUNT_DEF,
	parameter int CHUNK_BYTES = frsm_pkg::CHUNK_BYTES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  frsm_pkg::frsm_cmd_t               cmd,
	output frsm_pkg::frsm_sts_t               sts,
	input  logic                              op,
	input  logic [frsm_pkg::STAMP_W-1:0]      stamp,
	input  logic [frsm_pkg::CHUNK_W-1:0]      chunk_index,
	input  logic [frsm_pkg::CHUNK_W-1:0]      chunk_total,
	input  logic [frsm_pkg::BYTES_W-1:0]      frame_bytes,
	input  logic [frsm_pkg::DIM_W-1:0]        frame_width,
	input  logic [frsm_pkg::DIM_W-1:0]        frame_height,
	input  logic [frsm_pkg::FMT_W-1:0]        pixel_format,
	input  logic                              out_stall,
	output logic                              out_valid,
	output logic [frsm_pkg::SLOTID_W-1:0]     slot_used,
	output logic [frsm_pkg::OFFSET_W-1:0]     byte_offset,
	output logic                              evicted,
	output logic                              complete,
	output logic                              found,
	output logic [frsm_pkg::STAMP_W-1:0]      out_stamp,
	output logic [frsm_pkg::BYTES_W-1:0]      out_bytes,
	output logic [frsm_pkg::DIM_W-1:0]        out_width,
	output logic [frsm_pkg::DIM_W-1:0]        out_height,
	output logic [frsm_pkg::FMT_W-1:0]        out_format
);

	localparam int SW      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int KW      = $clog2(CHUNK_BYTES + 1);
	localparam int PW      = frsm_pkg::CHUNK_W + KW;
	localparam logic [KW-1:0] CHUNK_K = KW'(CHUNK_BYTES);
	localparam logic [frsm_pkg::CHUNK_W-1:0] COUNT_MAX = '1;

	logic                             op_q;
	logic [frsm_pkg::STAMP_W-1:0]     stamp_q;
	logic [frsm_pkg::CHUNK_W-1:0]     idx_q;
	logic [frsm_pkg::CHUNK_W-1:0]     total_q;
	logic [frsm_pkg::BYTES_W-1:0]     bytes_q;
	logic [frsm_pkg::DIM_W-1:0]       width_q;
	logic [frsm_pkg::DIM_W-1:0]       height_q;
	logic [frsm_pkg::FMT_W-1:0]       fmt_q;

	logic [frsm_pkg::STAMP_W-1:0]     slot_stamp_q  [SLOT_COUNT];
	logic [frsm_pkg::CHUNK_W-1:0]     slot_count_q  [SLOT_COUNT];
	logic                             slot_ready_q  [SLOT_COUNT];
	logic [frsm_pkg::BYTES_W-1:0]     slot_bytes_q  [SLOT_COUNT];
	logic [frsm_pkg::DIM_W-1:0]       slot_width_q  [SLOT_COUNT];
	logic [frsm_pkg::DIM_W-1:0]       slot_height_q [SLOT_COUNT];
	logic [frsm_pkg::FMT_W-1:0]       slot_format_q [SLOT_COUNT];
	logic [frsm_pkg::STAMP_W-1:0]     latest_q;

	logic [SW-1:0]                    scan_q;
	logic                             match_hit_q;
	logic [SW-1:0]                    match_idx_q;
	logic                             empty_hit_q;
	logic [SW-1:0]                    empty_idx_q;
	logic [SW-1:0]                    old_idx_q;
	logic [frsm_pkg::STAMP_W-1:0]     old_stamp_q;
	logic                             new_hit_q;
	logic [SW-1:0]                    new_idx_q;
	logic [frsm_pkg::STAMP_W-1:0]     new_stamp_q;

	logic [frsm_pkg::STAMP_W-1:0]     cur_stamp;
	logic [frsm_pkg::CHUNK_W-1:0]     cur_count;
	logic                             cur_ready;

	logic [SW-1:0]                    sel;
	logic                             evict;
	logic [frsm_pkg::CHUNK_W-1:0]     base_count;
	logic [frsm_pkg::CHUNK_W-1:0]     next_count;
	logic                             done;
	logic [PW-1:0]                    prod;

	assign cur_stamp = slot_stamp_q[scan_q];
	assign cur_count = slot_count_q[scan_q];
	assign cur_ready = slot_ready_q[scan_q];

	assign sts.scan_last   = (scan_q == SW'(SLOT_COUNT - 1));
	assign sts.out_blocked = out_valid && out_stall;

	always_comb begin
		evict = 1'b0;
		if (match_hit_q) begin
			sel = match_idx_q;
		end else if (empty_hit_q) begin
			sel = empty_idx_q;
		end else begin
			sel   = old_idx_q;
			evict = 1'b1;
		end
		base_count = evict ? '0 : slot_count_q[sel];
		next_count = (base_count == COUNT_MAX) ? base_count : base_count + 1'b1;
		done       = (next_count >= total_q);
		prod       = PW'(idx_q) * PW'(CHUNK_K);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= op;
			stamp_q  <= stamp;
			idx_q    <= chunk_index;
			total_q  <= chunk_total;
			bytes_q  <= frame_bytes;
			width_q  <= frame_width;
			height_q <= frame_height;
			fmt_q    <= pixel_format;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q      <= '0;
			match_hit_q <= 1'b0;
			match_idx_q <= '0;
			empty_hit_q <= 1'b0;
			empty_idx_q <= '0;
			old_idx_q   <= '0;
			old_stamp_q <= '0;
			new_hit_q   <= 1'b0;
			new_idx_q   <= '0;
			new_stamp_q <= '0;
		end else if (cmd.load) begin
			scan_q      <= '0;
			match_hit_q <= 1'b0;
			empty_hit_q <= 1'b0;
			new_hit_q   <= 1'b0;
		end else if (cmd.scan) begin
			if (!sts.scan_last) begin
				scan_q <= scan_q + 1'b1;
			end
			if (!match_hit_q && (cur_stamp == stamp_q)) begin
				match_hit_q <= 1'b1;
				match_idx_q <= scan_q;
			end
			if (!empty_hit_q && (cur_count == '0)) begin
				empty_hit_q <= 1'b1;
				empty_idx_q <= scan_q;
			end
			if ((scan_q == '0) || (cur_stamp < old_stamp_q)) begin
				old_idx_q   <= scan_q;
				old_stamp_q <= cur_stamp;
			end
			if (cur_ready && (!new_hit_q || (cur_stamp > new_stamp_q))) begin
				new_hit_q   <= 1'b1;
				new_idx_q   <= scan_q;
				new_stamp_q <= cur_stamp;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				slot_stamp_q[i]  <= '0;
				slot_count_q[i]  <= '0;
				slot_ready_q[i]  <= 1'b0;
				slot_bytes_q[i]  <= '0;
				slot_width_q[i]  <= '0;
				slot_height_q[i] <= '0;
				slot_format_q[i] <= '0;
			end
			latest_q <= '0;
		end else if (cmd.commit) begin
			if (op_q == frsm_pkg::OP_PACKET) begin
				for (int i = 0; i < SLOT_COUNT; i++) begin
					if (sel == SW'(i)) begin
						slot_stamp_q[i]  <= stamp_q;
						slot_count_q[i]  <= next_count;
						slot_ready_q[i]  <= done || (!evict && slot_ready_q[i]);
						slot_bytes_q[i]  <= bytes_q;
						slot_width_q[i]  <= width_q;
						slot_height_q[i] <= height_q;
						slot_format_q[i] <= fmt_q;
					end
				end
				if (done) begin
					latest_q <= stamp_q;
				end
			end else begin
				for (int i = 0; i < SLOT_COUNT; i++) begin
					if (slot_ready_q[i] || (slot_stamp_q[i] < latest_q)) begin
						slot_stamp_q[i]  <= '0;
						slot_count_q[i]  <= '0;
						slot_ready_q[i]  <= 1'b0;
						slot_bytes_q[i]  <= '0;
						slot_width_q[i]  <= '0;
						slot_height_q[i] <= '0;
						slot_format_q[i] <= '0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.commit) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			if (op_q == frsm_pkg::OP_PACKET) begin
				slot_used   <= frsm_pkg::SLOTID_W'(sel);
				byte_offset <= prod[frsm_pkg::OFFSET_W-1:0];
				evicted     <= evict;
				complete    <= done;
				found       <= 1'b0;
				out_stamp   <= '0;
				out_bytes   <= '0;
				out_width   <= '0;
				out_height  <= '0;
				out_format  <= '0;
			end else begin
				byte_offset <= '0;
				evicted     <= 1'b0;
				complete    <= 1'b0;
				found       <= new_hit_q;
				if (new_hit_q) begin
					slot_used  <= frsm_pkg::SLOTID_W'(new_idx_q);
					out_stamp  <= slot_stamp_q[new_idx_q];
					out_bytes  <= slot_bytes_q[new_idx_q];
					out_width  <= slot_width_q[new_idx_q];
					out_height <= slot_height_q[new_idx_q];
					out_format <= slot_format_q[new_idx_q];
				end else begin
					slot_used  <= '0;
					out_stamp  <= '0;
					out_bytes  <= '0;
					out_width  <= '0;
					out_height <= '0;
					out_format <= '0;
				end
			end
		end
	end

endmodule

@@ rtl/frame_reassembly_slot_manager.sv @@
// Each item takes an accept step, a scan step per slot through the single shared
// match/empty/oldest/newest comparator set, and a commit step; in_stall holds off new
// beats until the commit. A new beat is taken while the previous result waits.
// Reset (arst_n low) clears all slots, the latest complete stamp and out_valid.
`timescale 1ns / 1ps
module frame_reassembly_slot_manager #(
	parameter int SLOT_COUNT  = frsm_pkg::SLOT_COUNT_DEF,
	parameter int CHUNK_BYTES = frsm_pkg::CHUNK_BYTES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              op,
	input  logic [frsm_pkg::STAMP_W-1:0]      stamp,
	input  logic [frsm_pkg::CHUNK_W-1:0]      chunk_index,
	input  logic [frsm_pkg::CHUNK_W-1:0]      chunk_total,
	input  logic [frsm_pkg::BYTES_W-1:0]      frame_bytes,
	input  logic [frsm_pkg::DIM_W-1:0]        frame_width,
	input  logic [frsm_pkg::DIM_W-1:0]        frame_height,
	input  logic [frsm_pkg::FMT_W-1:0]        pixel_format,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [frsm_pkg::SLOTID_W-1:0]     slot_used,
	output logic [frsm_pkg::OFFSET_W-1:0]     byte_offset,
	output logic                              evicted,
	output logic                              complete,
	output logic                              found,
	output logic [frsm_pkg::STAMP_W-1:0]      out_stamp,
	output logic [frsm_pkg::BYTES_W-1:0]      out_bytes,
	output logic [frsm_pkg::DIM_W-1:0]        out_width,
	output logic [frsm_pkg::DIM_W-1:0]        out_height,
	output logic [frsm_pkg::FMT_W-1:0]        out_format
);

	frsm_pkg::frsm_cmd_t cmd;
	frsm_pkg::frsm_sts_t sts;

	frsm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	frsm_dp #(
		.SLOT_COUNT  (SLOT_COUNT),
		.CHUNK_BYTES (CHUNK_BYTES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.op           (op),
		.stamp        (stamp),
		.chunk_index  (chunk_index),
		.chunk_total  (chunk_total),
		.frame_bytes  (frame_bytes),
		.frame_width  (frame_width),
		.frame_height (frame_height),
		.pixel_format (pixel_format),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.slot_used    (slot_used),
		.byte_offset  (byte_offset),
		.evicted      (evicted),
		.complete     (complete),
		.found        (found),
		.out_stamp    (out_stamp),
		.out_bytes    (out_bytes),
		.out_width    (out_width),
		.out_height   (out_height),
		.out_format   (out_format)
	);

	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !(out_valid && out_stall))
		else $error("commit while output beat is held");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input not stalled after accept");

	a_out_from_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(cmd.commit))
		else $error("output beat without commit");

	a_found_xor_complete: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(found && complete))
		else $error("packet and fetch flags both set");

endmodule
